/* sv/rau_pkg.sv */
package rau_pkg;

  // Result range: signed WORD_BITS-bit numerator, denominator up to 2^(WORD_BITS-1)-1.
  localparam int WORD_BITS = 64;
  localparam logic [127:0] LIM = (128'd1 << (WORD_BITS - 1)) - 128'd1;

  // Operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] a_num;
    logic [62:0]        a_den;
    logic signed [63:0] b_num;
    logic [62:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         status;
  } out_item_t;

  // A classified job: numerator is (+/-)nx1*ny1 (+/-) nx2*ny2, denominator dx*dy.
  typedef struct packed {
    logic        div0;
    logic        is_add;
    logic        neg1;
    logic        neg2;
    logic [63:0] nx1;
    logic [63:0] ny1;
    logic [63:0] nx2;
    logic [63:0] ny2;
    logic [63:0] dx;
    logic [63:0] dy;
  } job_t;

  // Handshake between the front queue and the back sequencer.
  typedef struct packed {
    logic valid;
  } job_stat_t;

endpackage

/* sv/rau_front.sv */
module rau_front import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output job_stat_t job_stat,
  input  logic      job_pop,
  output job_t      job
);

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       cls;
  logic [63:0] an_u, bn_u, amag, bmag, ad, bd;
  logic        sa, sb, wr, rd;

  // Classify the incoming transaction into three products and their signs.
  always_comb begin
    an_u = in_data.a_num;
    bn_u = in_data.b_num;
    sa   = an_u[63];
    sb   = bn_u[63];
    amag = sa ? (~an_u + 64'd1) : an_u;
    bmag = sb ? (~bn_u + 64'd1) : bn_u;
    ad   = {1'b0, in_data.a_den};
    bd   = {1'b0, in_data.b_den};
    cls  = '0;
    cls.dx   = ad;
    cls.dy   = bd;
    cls.div0 = (ad == 64'd0) || (bd == 64'd0);
    unique case (in_data.op)
      OP_ADD, OP_SUB: begin
        cls.is_add = 1'b1;
        cls.nx1    = amag;
        cls.ny1    = bd;
        cls.neg1   = sa;
        cls.nx2    = bmag;
        cls.ny2    = ad;
        cls.neg2   = sb ^ (in_data.op == OP_SUB);
      end
      OP_MUL: begin
        cls.nx1  = amag;
        cls.ny1  = bmag;
        cls.neg1 = sa ^ sb;
      end
      default: begin
        cls.nx1  = amag;
        cls.ny1  = bd;
        cls.neg1 = sa ^ sb;
        cls.dy   = bmag;
        if (bmag == 64'd0) begin
          cls.div0 = 1'b1;
        end
      end
    endcase
  end

  assign in_full        = (cnt_r == 2'd2);
  assign wr             = in_push && !in_full;
  assign job_stat.valid = (cnt_r != 2'd0);
  assign rd             = job_pop && job_stat.valid;
  assign job            = q_r[rp_r];

  // Two-entry job queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        q_r[wp_r] <= cls;
        wp_r      <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* sv/rau_back.sv */
module rau_back import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_stat_t job_stat,
  output logic      job_pop,
  input  job_t      job,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]   state_r;
  job_t         job_r;
  logic [1:0]   pi_r, qt_r;
  logic [127:0] acc_r, p1_r, p2_r, n_r, d_r, u_r, v_r, dvs_r, rem_r, quo_r;
  logic [6:0]   k_r, cnt_r;
  logic         neg_r, zero_r, dsel_r;
  logic [63:0]  xsel, ysel, pp;
  logic [31:0]  xh, yh;
  logic [1:0]   qsum;
  logic [127:0] pp_sh, acc_nxt, comb_n, sh, quo_nxt;
  logic [128:0] trial;
  logic         comb_neg, qbit, ovf;
  logic [127:0] nlim;
  out_item_t    res;
  out_item_t    of_r [2];
  logic         owp_r, orp_r, ofull, owr, ord;
  logic [1:0]   ocnt_r;

  assign job_pop = (state_r == S_IDLE) && job_stat.valid;

  // Partial product of the current product: one 32 x 32 multiply a cycle.
  always_comb begin
    case (pi_r)
      2'd0:    begin xsel = job_r.nx1; ysel = job_r.ny1; end
      2'd1:    begin xsel = job_r.nx2; ysel = job_r.ny2; end
      default: begin xsel = job_r.dx;  ysel = job_r.dy;  end
    endcase
    xh    = qt_r[1] ? xsel[63:32] : xsel[31:0];
    yh    = qt_r[0] ? ysel[63:32] : ysel[31:0];
    pp    = {32'd0, xh} * {32'd0, yh};
    qsum  = {1'b0, qt_r[1]} + {1'b0, qt_r[0]};
    case (qsum)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    acc_nxt = acc_r + pp_sh;
  end

  // Signed combination of the two numerator terms.
  always_comb begin
    if (!job_r.is_add) begin
      comb_n   = p1_r;
      comb_neg = job_r.neg1;
    end else if (job_r.neg1 == job_r.neg2) begin
      comb_n   = p1_r + p2_r;
      comb_neg = job_r.neg1;
    end else if (p1_r >= p2_r) begin
      comb_n   = p1_r - p2_r;
      comb_neg = job_r.neg1;
    end else begin
      comb_n   = p2_r - p1_r;
      comb_neg = job_r.neg2;
    end
  end

  // One step of restoring division.
  always_comb begin
    sh      = {rem_r[126:0], quo_r[127]};
    trial   = {1'b0, sh} - {1'b0, dvs_r};
    qbit    = !trial[128];
    quo_nxt = {quo_r[126:0], qbit};
  end

  // Range check and result formatting.
  always_comb begin
    nlim = neg_r ? (LIM + 128'd1) : LIM;
    ovf  = (n_r > nlim) || (d_r > LIM);
    res  = '0;
    res.res_den = 63'd1;
    if (job_r.div0) begin
      res.status = ST_DIV0;
    end else if (zero_r) begin
      res.status = ST_OK;
    end else if (ovf) begin
      res.status = ST_OVF;
    end else begin
      res.status  = ST_OK;
      res.res_num = neg_r ? (~n_r[63:0] + 64'd1) : n_r[63:0];
      res.res_den = d_r[62:0];
    end
  end

  // Sequencer: products, combination, binary gcd, two exact divisions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_stat.valid) begin
            job_r  <= job;
            zero_r <= 1'b0;
            pi_r   <= 2'd0;
            qt_r   <= 2'd0;
            acc_r  <= '0;
            state_r <= job.div0 ? S_EMIT : S_MUL;
          end
        end
        S_MUL: begin
          qt_r <= qt_r + 2'd1;
          if (qt_r == 2'd3) begin
            acc_r <= '0;
            pi_r  <= pi_r + 2'd1;
            case (pi_r)
              2'd0:    p1_r <= acc_nxt;
              2'd1:    p2_r <= acc_nxt;
              default: begin
                d_r     <= acc_nxt;
                state_r <= S_COMB;
              end
            endcase
          end else begin
            acc_r <= acc_nxt;
          end
        end
        S_COMB: begin
          n_r   <= comb_n;
          neg_r <= comb_neg;
          u_r   <= comb_n;
          v_r   <= d_r;
          k_r   <= 7'd0;
          if (comb_n == 128'd0) begin
            zero_r  <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (u_r == v_r) begin
            dvs_r   <= u_r << k_r;
            rem_r   <= '0;
            quo_r   <= n_r;
            cnt_r   <= 7'd0;
            dsel_r  <= 1'b0;
            state_r <= S_DIV;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 7'd1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r > v_r) begin
            u_r <= u_r - v_r;
          end else begin
            v_r <= v_r - u_r;
          end
        end
        S_DIV: begin
          rem_r <= qbit ? trial[127:0] : sh;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd127) begin
            if (!dsel_r) begin
              n_r    <= quo_nxt;
              rem_r  <= '0;
              quo_r  <= d_r;
              dsel_r <= 1'b1;
            end else begin
              d_r     <= quo_nxt;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!ofull) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Two-entry result queue.
  assign ofull     = (ocnt_r == 2'd2);
  assign owr       = (state_r == S_EMIT) && !ofull;
  assign out_empty = (ocnt_r == 2'd0);
  assign ord       = out_pop && !out_empty;
  assign out_data  = of_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (owr) begin
        of_r[owp_r] <= res;
        owp_r       <= ~owp_r;
      end
      if (ord) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_r + {1'b0, owr} - {1'b0, ord};
    end
  end

endmodule

/* sv/rational_arithmetic_unit.sv */
// Sequence: three products from 32 x 32 partial products, the numerator combination,
// a binary gcd, and two exact restoring divisions of numerator and denominator.
// A division by zero skips the arithmetic; a zero result skips the gcd and divisions.
// Throughput: one transaction at a time in the back sequencer; the shared 128-bit
// divider and the gcd subtractor bound the rate. Two-entry queues sit on both sides.
// Reset: synchronous, active low; it empties both queues and idles the sequencer.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  job_stat_t job_stat;
  job_t      job;
  logic      job_pop;

  // Front: accepts and classifies transactions.
  rau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .job_stat (job_stat),
    .job_pop  (job_pop),
    .job      (job)
  );

  // Back: carries out the arithmetic and queues the results.
  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_stat  (job_stat),
    .job_pop   (job_pop),
    .job       (job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
